// ===== hdl/jltg_pkg.sv =====
// ----------------------------------------------------------------------------
// jltg_pkg
// Types and constants shared by the joint linear trajectory generator.
// ----------------------------------------------------------------------------
package jltg_pkg;

   localparam int unsigned FuncW = 2;
   localparam int unsigned JointW = 4;
   localparam int unsigned DataW = 32;
   localparam int unsigned MagW = 33;
   localparam int unsigned DividendW = 65;
   localparam int unsigned DivCntW = 7;

   typedef enum logic [FuncW-1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_PLAN = 2'd1,
      FUNC_ADVANCE = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLAN_DIV,
      ST_PLAN_DONE,
      ST_ADV_READ,
      ST_ADV_MUL,
      ST_ADV_DIVP,
      ST_ADV_DIVV,
      ST_ADV_EMIT,
      ST_ADV_WAIT,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic load_wr;
      logic clear_wr;
      logic scan_reset;
      logic scan_step;
      logic plan_div_start;
      logic plan_commit;
      logic read_joint;
      logic mul_start;
      logic divp_start;
      logic divv_start;
      logic vel_capture;
      logic pos_capture;
      logic emit;
      logic time_advance;
      logic next_joint;
      logic clear_all;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
      logic scan_last;
      logic joint_last;
      logic out_busy;
   } status_type;

endpackage

// ===== hdl/jltg_req_if.sv =====
// ----------------------------------------------------------------------------
// jltg_req_if
// Request channel: valid/ready with one item per beat.
// ----------------------------------------------------------------------------
interface jltg_req_if;
   logic valid;
   logic ready;
   logic [jltg_pkg::FuncW-1:0] func;
   logic [jltg_pkg::JointW-1:0] joint_index;
   logic signed [jltg_pkg::DataW-1:0] start_position;
   logic signed [jltg_pkg::DataW-1:0] goal_position;
   logic [jltg_pkg::DataW-1:0] time_step;

   modport source (output valid, func, joint_index, start_position, goal_position,
                   time_step, input ready);
   modport sink (input valid, func, joint_index, start_position, goal_position,
                 time_step, output ready);
endinterface

// ===== hdl/jltg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// jltg_rsp_if
// Response channel: valid/ready with one joint result per beat.
// ----------------------------------------------------------------------------
interface jltg_rsp_if;
   logic valid;
   logic ready;
   logic [jltg_pkg::JointW-1:0] out_joint;
   logic signed [jltg_pkg::DataW-1:0] desired_position;
   logic signed [jltg_pkg::DataW-1:0] desired_velocity;
   logic [jltg_pkg::DataW-1:0] elapsed_time;
   logic [jltg_pkg::DataW-1:0] planned_duration;
   logic last;

   modport source (output valid, out_joint, desired_position, desired_velocity,
                   elapsed_time, planned_duration, last, input ready);
   modport sink (input valid, out_joint, desired_position, desired_velocity,
                 elapsed_time, planned_duration, last, output ready);
endinterface

// ===== hdl/jltg_divider.sv =====
// ----------------------------------------------------------------------------
// jltg_divider
// Radix-2 restoring divider, 65-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module jltg_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [jltg_pkg::DividendW-1:0] dividend,
   input  logic [jltg_pkg::DataW-1:0] divisor,
   output logic done,
   output logic [jltg_pkg::DividendW-1:0] quotient
);
   logic [jltg_pkg::DividendW-1:0] quot_ff, quot_in;
   logic [jltg_pkg::DataW:0] rem_ff, rem_in;
   logic [jltg_pkg::DataW-1:0] dvs_ff, dvs_in;
   logic [jltg_pkg::DivCntW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [jltg_pkg::DataW+1:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quot_ff[jltg_pkg::DividendW-1]} - {2'b00, dvs_ff};
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = jltg_pkg::DivCntW'(jltg_pkg::DividendW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[jltg_pkg::DataW+1]) begin
            rem_in = trial[jltg_pkg::DataW:0];
            quot_in = {quot_ff[jltg_pkg::DividendW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[jltg_pkg::DataW-1:0], quot_ff[jltg_pkg::DividendW-1]};
            quot_in = {quot_ff[jltg_pkg::DividendW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == jltg_pkg::DivCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quot_ff;
endmodule

// ===== hdl/jltg_datapath.sv =====
// ----------------------------------------------------------------------------
// jltg_datapath
// Joint stores, time and duration registers, multiplier, divider, output stage.
// ----------------------------------------------------------------------------
module jltg_datapath #(
   parameter int unsigned JOINTS = 12
) (
   input  logic clock,
   input  logic reset,
   input  jltg_pkg::cmd_type cmd,
   output jltg_pkg::status_type status,
   input  logic [jltg_pkg::DataW-1:0] max_vel,
   input  logic [jltg_pkg::JointW-1:0] req_joint,
   input  logic [jltg_pkg::DataW-1:0] req_start,
   input  logic [jltg_pkg::DataW-1:0] req_goal,
   input  logic [jltg_pkg::DataW-1:0] req_step,
   jltg_rsp_if.source rsp
);
   localparam int unsigned IdxW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int unsigned DW = jltg_pkg::DataW;
   localparam int unsigned MW = jltg_pkg::MagW;
   localparam int unsigned QW = jltg_pkg::DividendW;

   logic [DW-1:0] start_ff [JOINTS];
   logic [DW-1:0] goal_ff [JOINTS];
   logic [JOINTS-1:0] vld_ff;
   logic [DW-1:0] time_ff, dur_ff;
   logic [IdxW-1:0] idx_ff;
   logic [MW-1:0] move_ff;
   logic [DW-1:0] st_ff, gl_ff;
   logic neg_ff;
   logic [MW-1:0] mag_ff;
   logic [QW-1:0] prod_ff;
   logic mul_done_ff;
   logic [DW-1:0] pos_ff, vel_ff;
   logic [DW-1:0] ovld_pos_ff, ovld_vel_ff;
   logic ovalid_ff;
   logic [jltg_pkg::JointW-1:0] ojoint_ff;
   logic [DW-1:0] otime_ff, odur_ff;
   logic olast_ff;

   logic [DW-1:0] cur_start, cur_goal;
   logic [MW-1:0] diff, mag;
   logic div_start;
   logic [QW-1:0] div_dividend, div_q;
   logic div_done;
   logic [DW:0] tsum;
   logic [DW-1:0] vel_sat, pos_calc;
   logic [DW-1:0] plan_dur;
   logic load_ok;

   assign load_ok = cmd.load_wr &&
                    ({1'b0, req_joint} < (jltg_pkg::JointW+1)'(JOINTS));

   assign cur_start = vld_ff[idx_ff] ? start_ff[idx_ff] : '0;
   assign cur_goal = vld_ff[idx_ff] ? goal_ff[idx_ff] : '0;
   assign diff = {cur_goal[DW-1], cur_goal} - {cur_start[DW-1], cur_start};
   assign mag = diff[MW-1] ? (~diff + 1'b1) : diff;

   always_comb begin
      div_start = cmd.plan_div_start | cmd.divp_start | cmd.divv_start;
      div_dividend = '0;
      if (cmd.plan_div_start) begin
         div_dividend = QW'({move_ff, 16'h0000});
      end else if (cmd.divp_start) begin
         div_dividend = prod_ff;
      end else begin
         div_dividend = QW'({mag_ff, 16'h0000});
      end
   end

   jltg_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_dividend), .divisor(cmd.plan_div_start ? max_vel : dur_ff),
      .done(div_done), .quotient(div_q)
   );

   always_comb begin
      if (div_q[QW-1:DW] != '0) begin
         plan_dur = '1;
      end else if (div_q[DW-1:0] == '0) begin
         plan_dur = DW'(1);
      end else begin
         plan_dur = div_q[DW-1:0];
      end
      if (neg_ff) begin
         vel_sat = (div_q > QW'(33'h080000000)) ? 32'h80000000
                                                  : (~div_q[DW-1:0] + 1'b1);
      end else begin
         vel_sat = (div_q > QW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : div_q[DW-1:0];
      end
      pos_calc = neg_ff ? (st_ff - div_q[DW-1:0]) : (st_ff + div_q[DW-1:0]);
      tsum = {1'b0, time_ff} + {1'b0, req_step};
   end

   always_ff @(posedge clock) begin
      if (load_ok) begin
         start_ff[req_joint[IdxW-1:0]] <= req_start;
         goal_ff[req_joint[IdxW-1:0]] <= req_goal;
      end
      if (cmd.read_joint) begin
         st_ff <= cur_start;
         gl_ff <= cur_goal;
         neg_ff <= diff[MW-1];
         mag_ff <= mag;
      end
      if (cmd.mul_start) begin
         prod_ff <= QW'(mag_ff) * QW'(time_ff);
      end
      if (cmd.vel_capture) begin
         vel_ff <= vel_sat;
      end
      if (cmd.pos_capture) begin
         pos_ff <= pos_calc;
      end
      if (cmd.emit) begin
         ojoint_ff <= jltg_pkg::JointW'(idx_ff);
         otime_ff <= time_ff;
         odur_ff <= dur_ff;
         olast_ff <= (idx_ff == IdxW'(JOINTS - 1));
         if (dur_ff == '0) begin
            ovld_pos_ff <= st_ff;
            ovld_vel_ff <= '0;
         end else if (time_ff >= dur_ff) begin
            ovld_pos_ff <= gl_ff;
            ovld_vel_ff <= '0;
         end else begin
            ovld_pos_ff <= pos_ff;
            ovld_vel_ff <= vel_ff;
         end
      end
      if (reset) begin
         vld_ff <= '0;
         time_ff <= '0;
         dur_ff <= '0;
         idx_ff <= '0;
         move_ff <= '0;
         mul_done_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         mul_done_ff <= cmd.mul_start;
         if (load_ok) begin
            vld_ff[req_joint[IdxW-1:0]] <= 1'b1;
         end
         if (cmd.clear_all) begin
            vld_ff <= '0;
            time_ff <= '0;
            dur_ff <= '0;
         end
         if (cmd.scan_reset) begin
            idx_ff <= '0;
            move_ff <= '0;
         end else if (cmd.scan_step) begin
            if (mag > move_ff) begin
               move_ff <= mag;
            end
            idx_ff <= idx_ff + 1'b1;
         end else if (cmd.next_joint) begin
            idx_ff <= (idx_ff == IdxW'(JOINTS - 1)) ? '0 : idx_ff + 1'b1;
         end
         if (cmd.plan_commit) begin
            time_ff <= '0;
            dur_ff <= (max_vel == '0) ? DW'(1) : plan_dur;
            idx_ff <= '0;
         end
         if (cmd.time_advance) begin
            time_ff <= tsum[DW] ? '1 : tsum[DW-1:0];
         end
         if (cmd.emit) begin
            ovalid_ff <= 1'b1;
         end else if (rsp.ready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   assign status.div_done = div_done;
   assign status.mul_done = mul_done_ff;
   assign status.scan_last = (idx_ff == IdxW'(JOINTS - 1));
   assign status.joint_last = (idx_ff == IdxW'(JOINTS - 1));
   assign status.out_busy = ovalid_ff & ~rsp.ready;

   assign rsp.valid = ovalid_ff;
   assign rsp.out_joint = ojoint_ff;
   assign rsp.desired_position = ovld_pos_ff;
   assign rsp.desired_velocity = ovld_vel_ff;
   assign rsp.elapsed_time = otime_ff;
   assign rsp.planned_duration = odur_ff;
   assign rsp.last = olast_ff;
endmodule

// ===== hdl/jltg_controller.sv =====
// ----------------------------------------------------------------------------
// jltg_controller
// Sequencer for load, plan, advance and clear requests.
// ----------------------------------------------------------------------------
module jltg_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic [jltg_pkg::FuncW-1:0] req_func,
   output logic req_ready,
   input  jltg_pkg::status_type status,
   output jltg_pkg::cmd_type cmd
);
   jltg_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jltg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         jltg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (jltg_pkg::func_type'(req_func))
                  jltg_pkg::FUNC_LOAD: cmd.load_wr = 1'b1;
                  jltg_pkg::FUNC_PLAN: begin
                     cmd.scan_reset = 1'b1;
                     state_in = jltg_pkg::ST_SCAN;
                  end
                  jltg_pkg::FUNC_ADVANCE: state_in = jltg_pkg::ST_ADV_READ;
                  jltg_pkg::FUNC_CLEAR: cmd.clear_all = 1'b1;
                  default: ;
               endcase
            end
         end
         jltg_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = jltg_pkg::ST_PLAN_DIV;
            end
         end
         jltg_pkg::ST_PLAN_DIV: begin
            cmd.plan_div_start = 1'b1;
            state_in = jltg_pkg::ST_PLAN_DONE;
         end
         jltg_pkg::ST_PLAN_DONE: begin
            if (status.div_done) begin
               cmd.plan_commit = 1'b1;
               state_in = jltg_pkg::ST_IDLE;
            end
         end
         jltg_pkg::ST_ADV_READ: begin
            cmd.read_joint = 1'b1;
            state_in = jltg_pkg::ST_ADV_MUL;
         end
         jltg_pkg::ST_ADV_MUL: begin
            cmd.mul_start = 1'b1;
            state_in = jltg_pkg::ST_ADV_DIVP;
         end
         jltg_pkg::ST_ADV_DIVP: begin
            cmd.divv_start = 1'b1;
            state_in = jltg_pkg::ST_ADV_DIVV;
         end
         jltg_pkg::ST_ADV_DIVV: begin
            if (status.div_done) begin
               cmd.vel_capture = 1'b1;
               cmd.divp_start = 1'b1;
               state_in = jltg_pkg::ST_ADV_WAIT;
            end
         end
         jltg_pkg::ST_ADV_WAIT: begin
            if (status.div_done) begin
               cmd.pos_capture = 1'b1;
               state_in = jltg_pkg::ST_ADV_EMIT;
            end
         end
         jltg_pkg::ST_ADV_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               cmd.next_joint = 1'b1;
               if (status.joint_last) begin
                  cmd.time_advance = 1'b1;
                  state_in = jltg_pkg::ST_CLEAR;
               end else begin
                  state_in = jltg_pkg::ST_ADV_READ;
               end
            end
         end
         jltg_pkg::ST_CLEAR: begin
            state_in = jltg_pkg::ST_IDLE;
         end
         default: state_in = jltg_pkg::ST_IDLE;
      endcase
   end
endmodule

// ===== hdl/joint_linear_trajectory_generator.sv =====
// Load, clear: done in the idle state. Plan: a joint scan, then a 65-step divide.
// Advance: two 65-step divides per joint on one shared divider, held while the
// output is stalled; JOINTS results per advance.
// Synchronous active-high reset clears valid bits, time, duration and max velocity.
// ----------------------------------------------------------------------------
// joint_linear_trajectory_generator
// Multi-joint linear trajectory generator, Q16.16 fixed point.
// ----------------------------------------------------------------------------
module joint_linear_trajectory_generator #(
   parameter int unsigned JOINTS = 12
) (
   input  logic clock,
   input  logic reset,
   jltg_req_if.sink req,
   jltg_rsp_if.source rsp,
   input  logic csr_we,
   input  logic [jltg_pkg::DataW-1:0] csr_wdata
);
   logic [jltg_pkg::DataW-1:0] max_vel_ff;
   logic ctl_ready;
   jltg_pkg::cmd_type cmd;
   jltg_pkg::status_type status;
   logic [jltg_pkg::DataW-1:0] step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_vel_ff <= '0;
      end else if (csr_we) begin
         max_vel_ff <= csr_wdata;
      end
      if (req.valid && ctl_ready) begin
         step_ff <= req.time_step;
      end
   end

   assign req.ready = ctl_ready;

   jltg_controller u_ctl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_func(req.func),
      .req_ready(ctl_ready), .status(status), .cmd(cmd)
   );

   jltg_datapath #(.JOINTS(JOINTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .max_vel(max_vel_ff), .req_joint(req.joint_index),
      .req_start(req.start_position), .req_goal(req.goal_position),
      .req_step(step_ff), .rsp(rsp)
   );
endmodule
